// ===== rtl/core/lsri_pkg.sv =====
package lsri_pkg;

	localparam int ADDR_BITS_DEF   = 16;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int COS_DEPTH_DEF   = 256;
	localparam int QUEUE_DEPTH     = 2;

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam logic signed [23:0] RECIP3 = 24'sd2796203;
	localparam logic signed [31:0] DIV3_BIAS = 32'sd6291456;
	localparam logic signed [31:0] DIV3_BASE = 32'sd2097152;

	localparam logic [2:0] CFG_SAMPLE_COUNT = 3'd0;
	localparam logic [2:0] CFG_START_OFFSET = 3'd1;
	localparam logic [2:0] CFG_PLAY_LENGTH  = 3'd2;
	localparam logic [2:0] CFG_ONE_SHOT     = 3'd3;
	localparam logic [2:0] CFG_INTERP_MODE  = 3'd4;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_TRIG = 2'd1,
		KIND_TICK = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NEAREST  = 3'd0,
		MODE_LINEAR   = 3'd1,
		MODE_CUBIC    = 3'd2,
		MODE_HOLD     = 3'd3,
		MODE_COSINE   = 3'd4,
		MODE_BSPLINE  = 3'd5,
		MODE_LAGRANGE = 3'd6,
		MODE_SILENT   = 3'd7
	} mode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_MOD,
		ST_IDX,
		ST_RD,
		ST_COEF,
		ST_HORNER,
		ST_DIV,
		ST_MULD,
		ST_MULL,
		ST_OUT
	} state_t;

	typedef struct packed {
		kind_t              kind;
		logic [15:0]        address;
		logic signed [15:0] value;
		logic [18:0]        increment;
	} item_t;

endpackage

// ===== rtl/core/lsri_front.sv =====
module lsri_front import lsri_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	item_t            buf_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [PW:0]      count_q;
	logic             push, pop;

	assign in_ready = (count_q < (PW+1)'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_item   = buf_q[rd_ptr_q];
	// drop unknown kinds here so the back end never sees them
	assign push     = in_valid && in_ready && (in_item.kind != KIND_NONE);
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PW+1)'(QUEUE_DEPTH))
		else $error("queue overfilled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue lost an item");
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_item.kind == KIND_NONE && !pop) |=> $stable(count_q))
		else $error("unknown kind entered queue");

endmodule

// ===== rtl/core/lsri_back.sv =====
module lsri_back import lsri_pkg::*; #(
	parameter int ADDR_BITS       = ADDR_BITS_DEF,
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	input  logic               cfg_valid,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               finished
);

	localparam int A   = ADDR_BITS;
	localparam int F   = FRAC_BITS;
	localparam int D   = COS_TABLE_DEPTH;
	localparam int CI  = $clog2(D);
	localparam int IW  = ((A + 4 > 17) ? A + 4 : 17) + 2;
	localparam int PW  = A + 4 + F;
	localparam int DW  = 2 * A + F + 4;
	localparam int MS  = A + 4;
	localparam int MCW = $clog2(MS + 1);
	localparam logic [IW-1:0] MEM_D = {{(IW-1){1'b0}}, 1'b1} << A;
	localparam logic signed [IW-1:0] ZERO_I = IW'(0);
	localparam logic signed [IW-1:0] ONE_I  = IW'(1);
	localparam logic signed [IW-1:0] TWO_I  = IW'(2);

	// cosine weight table, built at elaboration
	logic [16:0] cos_tab [D];
	for (genvar k = 0; k < D; k++) begin : g_cos
		localparam longint KK = (k <= D / 2) ? k : D - k;
		localparam longint AN = PI_Q30 * KK / D;
		localparam longint A2 = (AN * AN) >>> 30;
		localparam longint P1 = (-Q30_ONE * A2) >>> 30;
		localparam longint T1 = (P1 >= 0) ? P1 / 2 : -((-P1 + 1) / 2);
		localparam longint P2 = (-T1 * A2) >>> 30;
		localparam longint T2 = (P2 >= 0) ? P2 / 12 : -((-P2 + 11) / 12);
		localparam longint P3 = (-T2 * A2) >>> 30;
		localparam longint T3 = (P3 >= 0) ? P3 / 30 : -((-P3 + 29) / 30);
		localparam longint P4 = (-T3 * A2) >>> 30;
		localparam longint T4 = (P4 >= 0) ? P4 / 56 : -((-P4 + 55) / 56);
		localparam longint P5 = (-T4 * A2) >>> 30;
		localparam longint T5 = (P5 >= 0) ? P5 / 90 : -((-P5 + 89) / 90);
		localparam longint SM = Q30_ONE + T1 + T2 + T3 + T4 + T5;
		localparam longint EN = ((Q30_ONE - SM) + 64'sd16384) >>> 15;
		localparam logic [16:0] V = (k <= D / 2) ? 17'(EN) : 17'(64'sd65536 - EN);
		assign cos_tab[k] = V;
	end

	// configuration
	logic [16:0] cfg_count_q, cfg_len_q;
	logic [15:0] cfg_start_q;
	logic        cfg_oneshot_q;
	mode_t       cfg_mode_q;

	// state and datapath
	state_t                state_q, state_d;
	logic [PW-1:0]         pos_q;
	logic                  done_q;
	item_t                 cur_q;
	logic [PW-1:0]         rem_q;
	logic [DW-1:0]         div_q;
	logic [MCW-1:0]        mod_cnt_q;
	logic [A-1:0]          idx_q [4];
	logic [2:0]            rcnt_q;
	logic signed [15:0]    s_q [4];
	logic signed [21:0]    c_q [3];
	logic [1:0]            hstep_q;
	logic signed [31:0]    acc_q;
	logic [23:0]           u_q;
	logic [16:0]           w_q;
	logic signed [31:0]    y_q;
	logic                  res_fin_q;
	logic                  out_valid_q;
	logic signed [15:0]    sample_q;
	logic                  finished_q;
	logic [15:0]           rdata_q;

	logic [15:0]           mem [2**A];

	// derived window
	logic [IW-1:0] cnt_u, off_u, len_u, end_u, pl_u;
	logic [PW-1:0] endq, offq;
	logic [DW-1:0] lenq_sh;

	always_comb begin
		cnt_u = (cfg_count_q == '0) ? IW'(1) :
			((IW'(cfg_count_q) > MEM_D) ? MEM_D : IW'(cfg_count_q));
		off_u = (IW'(cfg_start_q) > cnt_u - 1'b1) ? cnt_u - 1'b1 : IW'(cfg_start_q);
		pl_u  = (cfg_len_q == '0) ? IW'(1) : IW'(cfg_len_q);
		len_u = (pl_u > cnt_u - off_u) ? cnt_u - off_u : pl_u;
		end_u = off_u + len_u;
	end

	assign endq    = PW'(end_u) << F;
	assign offq    = PW'(off_u) << F;
	assign lenq_sh = DW'(len_u) << (F + A + 3);

	// fraction as Q0.16 and increment in position units
	logic [15:0]   t;
	logic [PW-1:0] inc_ext;
	if (F >= 16) begin : g_frac_wide
		assign t       = pos_q[F-1 -: 16];
		assign inc_ext = PW'(cur_q.increment) << (F - 16);
	end else begin : g_frac_narrow
		assign t       = {pos_q[F-1:0], {(16-F){1'b0}}};
		assign inc_ext = PW'(cur_q.increment >> (16 - F));
	end

	logic [CI-1:0] cos_idx;
	assign cos_idx = CI'((32'(t) * D) >> 16);

	// neighbour indices
	logic [A-1:0] idx_d [4];
	always_comb begin
		logic signed [IW-1:0] i0, im1, i1, i2, cs, os, ls, es;
		cs  = signed'(cnt_u);
		os  = signed'(off_u);
		ls  = signed'(len_u);
		es  = signed'(end_u);
		i0  = signed'(IW'(pos_q[PW-1:F]));
		im1 = i0 - ONE_I;
		i1  = i0 + ONE_I;
		i2  = i0 + TWO_I;
		if (cfg_oneshot_q) begin
			if (im1 < ZERO_I) im1 = '0;
			if (i1 >= cs) i1 = i0;
			if (i2 >= cs) i2 = i1;
		end else begin
			if (im1 < os) im1 = im1 + ls;
			if (i1 >= es) i1 = i1 - ls;
			if (i2 >= es) i2 = i2 - ls;
		end
		if (im1 < ZERO_I) im1 = '0;
		if (im1 > cs - ONE_I) im1 = cs - ONE_I;
		if (i0 > cs - ONE_I) i0 = cs - ONE_I;
		if (i1 < ZERO_I) i1 = '0;
		if (i1 > cs - ONE_I) i1 = cs - ONE_I;
		if (i2 < ZERO_I) i2 = '0;
		if (i2 > cs - ONE_I) i2 = cs - ONE_I;
		idx_d[0] = A'(im1);
		idx_d[1] = A'(i0);
		idx_d[2] = A'(i1);
		idx_d[3] = A'(i2);
	end

	// polynomial coefficients
	logic signed [21:0] a3, a2, a1, a0;
	always_comb begin
		logic signed [21:0] m, z, p, q;
		m = 22'(s_q[0]);
		z = 22'(s_q[1]);
		p = 22'(s_q[2]);
		q = 22'(s_q[3]);
		unique case (cfg_mode_q)
			MODE_BSPLINE: begin
				a3 = 22'(q - 3 * p + 3 * z - m);
				a2 = 22'(3 * (m - 2 * z + p));
				a1 = 22'(3 * (p - m));
				a0 = 22'(m + 4 * z + p);
			end
			MODE_LAGRANGE: begin
				a3 = 22'(-m + 3 * z - 3 * p + q);
				a2 = 22'(3 * m - 6 * z + 3 * p);
				a1 = 22'(-2 * m - 3 * z + 6 * p - q);
				a0 = 22'(6 * z);
			end
			default: begin
				a3 = 22'(q - m + 3 * (z - p));
				a2 = 22'(2 * m - 5 * z + 4 * p - q);
				a1 = p - m;
				a0 = 22'(2 * z);
			end
		endcase
	end

	// shared multiplier
	logic signed [31:0] ma;
	logic signed [23:0] mb;
	logic signed [55:0] prod;
	logic               mem_we;
	logic [A-1:0]       raddr;
	logic [PW-1:0]      rem_n;
	logic [1:0]         rsel;

	assign prod  = ma * mb;
	assign rsel  = 2'(rcnt_q - 3'd1);
	assign rem_n = (DW'(rem_q) >= div_q) ? rem_q - PW'(div_q) : rem_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.kind == KIND_TICK) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (!done_q && pos_q >= endq) begin
					state_d = cfg_oneshot_q ? ST_OUT : ST_MOD;
				end else begin
					state_d = done_q ? ST_OUT : ST_IDX;
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == MCW'(1)) state_d = ST_IDX;
			end
			ST_IDX: state_d = ST_RD;
			ST_RD: begin
				if (rcnt_q == 3'd4) state_d = ST_COEF;
			end
			ST_COEF: begin
				unique case (cfg_mode_q)
					MODE_LINEAR, MODE_COSINE:               state_d = ST_MULL;
					MODE_CUBIC, MODE_BSPLINE, MODE_LAGRANGE: state_d = ST_HORNER;
					default:                                 state_d = ST_OUT;
				endcase
			end
			ST_HORNER: begin
				if (hstep_q == 2'd2) state_d = ST_DIV;
			end
			ST_DIV:  state_d = (cfg_mode_q == MODE_CUBIC) ? ST_OUT : ST_MULD;
			ST_MULD: state_d = ST_OUT;
			ST_MULL: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop  = (state_q == ST_IDLE);
		mem_we = (state_q == ST_IDLE) && q_valid && (q_item.kind == KIND_LOAD);
		raddr  = idx_q[rcnt_q[1:0]];
		ma     = acc_q;
		mb     = signed'({8'd0, t});
		unique case (state_q)
			ST_MULD: begin
				ma = signed'({8'd0, u_q});
				mb = RECIP3;
			end
			ST_MULL: begin
				ma = 32'(17'(s_q[2]) - 17'(s_q[1]));
				mb = signed'({7'd0, w_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[A'(q_item.address)] <= q_item.value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				cur_q     <= q_item;
				res_fin_q <= 1'b0;
			end
			ST_CHECK: begin
				rem_q     <= pos_q - endq;
				div_q     <= lenq_sh;
				mod_cnt_q <= MCW'(MS);
				res_fin_q <= done_q || (pos_q >= endq && cfg_oneshot_q);
				y_q       <= '0;
			end
			ST_MOD: begin
				rem_q     <= rem_n;
				div_q     <= div_q >> 1;
				mod_cnt_q <= mod_cnt_q - 1'b1;
			end
			ST_IDX: begin
				idx_q  <= idx_d;
				rcnt_q <= '0;
			end
			ST_RD: begin
				rcnt_q <= rcnt_q + 1'b1;
				if (rcnt_q != 3'd0) s_q[rsel] <= signed'(rdata_q);
			end
			ST_COEF: begin
				acc_q   <= 32'(a3) <<< 8;
				c_q[0]  <= a2;
				c_q[1]  <= a1;
				c_q[2]  <= a0;
				hstep_q <= '0;
				w_q     <= (cfg_mode_q == MODE_COSINE) ? cos_tab[cos_idx] : {1'b0, t};
				unique case (cfg_mode_q)
					MODE_NEAREST: y_q <= (t < 16'd32768) ? 32'(s_q[1]) : 32'(s_q[2]);
					MODE_HOLD:    y_q <= 32'(s_q[1]);
					default:      y_q <= '0;
				endcase
			end
			ST_HORNER: begin
				acc_q   <= 32'(prod >>> 16) + (32'(c_q[hstep_q]) <<< 8);
				hstep_q <= hstep_q + 1'b1;
			end
			ST_DIV: begin
				y_q <= (acc_q + 32'sd256) >>> 9;
				u_q <= 24'(((acc_q + 32'sd768) >>> 9) + DIV3_BIAS);
			end
			ST_MULD: y_q <= 32'(prod >>> 23) - DIV3_BASE;
			ST_MULL: y_q <= 32'(s_q[1]) + 32'((prod + 56'sd32768) >>> 16);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pos_q         <= '0;
			done_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			sample_q      <= '0;
			finished_q    <= 1'b0;
			cfg_count_q   <= 17'd1;
			cfg_start_q   <= '0;
			cfg_len_q     <= 17'd1;
			cfg_oneshot_q <= 1'b1;
			cfg_mode_q    <= MODE_LINEAR;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_SAMPLE_COUNT: cfg_count_q   <= cfg_data;
					CFG_START_OFFSET: cfg_start_q   <= cfg_data[15:0];
					CFG_PLAY_LENGTH:  cfg_len_q     <= cfg_data;
					CFG_ONE_SHOT:     cfg_oneshot_q <= cfg_data[0];
					CFG_INTERP_MODE:  cfg_mode_q    <= mode_t'(cfg_data[2:0]);
					default: ;
				endcase
			end
			// a trigger or a switch to loop mode clears the flag
			if ((state_q == ST_IDLE && q_valid && q_item.kind == KIND_TRIG)
					|| (cfg_valid && cfg_index == CFG_ONE_SHOT && !cfg_data[0])) begin
				done_q <= 1'b0;
			end else if (state_q == ST_CHECK && !done_q && pos_q >= endq && cfg_oneshot_q) begin
				done_q <= 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && q_item.kind == KIND_TRIG) pos_q <= offq;
				end
				ST_MOD: begin
					if (mod_cnt_q == MCW'(1)) pos_q <= offq + rem_n;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						finished_q <= res_fin_q;
						if (res_fin_q) begin
							sample_q <= '0;
						end else begin
							pos_q <= pos_q + inc_ext;
							if (y_q > 32'sd32767) sample_q <= 16'sh7fff;
							else if (y_q < -32'sd32768) sample_q <= 16'sh8000;
							else sample_q <= 16'(y_q);
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign finished  = finished_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (mod_cnt_q != '0 && mod_cnt_q <= MCW'(MS)))
		else $error("modulo step count out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDX && $past(state_q) == ST_MOD) |-> (pos_q < endq && pos_q >= offq))
		else $error("wrapped position outside window");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && res_fin_q) |-> done_q)
		else $error("finished result without done flag");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (rcnt_q <= 3'd4))
		else $error("read sequence overrun");

endmodule

// ===== rtl/core/looping_sample_reader_interpolator.sv =====
// A popped tick passes check, index, read and coefficient states to the result register;
// linear and cosine add a multiply, cubic adds Horner and divide steps, B-spline and
// Lagrange add a multiply by 1/3 too, a finished voice skips from check to output, and
// a wrap adds modulo steps. One memory read port fetches the four samples. One item at a
// time; a two-entry input queue takes items while the back end works or waits on output.
// Reset clears position, finished flag, queue and result; sample memory is not cleared.
module looping_sample_reader_interpolator import lsri_pkg::*; #(
	parameter int ADDR_BITS       = ADDR_BITS_DEF,
	parameter int FRAC_BITS       = FRAC_BITS_DEF,
	parameter int COS_TABLE_DEPTH = COS_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic [15:0]        address,
	input  logic signed [15:0] value,
	input  logic [18:0]        increment,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] sample,
	output logic               finished,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [16:0]        cfg_data
);

	item_t in_item, q_item;
	logic  q_valid, q_pop;

	assign in_item.kind      = kind_t'(kind);
	assign in_item.address   = address;
	assign in_item.value     = value;
	assign in_item.increment = increment;
	assign cfg_ready         = 1'b1;

	lsri_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	lsri_back #(
		.ADDR_BITS       (ADDR_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.COS_TABLE_DEPTH (COS_TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.finished  (finished)
	);

endmodule
